/* hdl/obar_pkg.sv */
`default_nettype none
package obar_pkg;

  localparam int BOOK_DEPTH_DEF = 8;
  localparam int NUM_STOCKS_DEF = 4;

  localparam int FIELD_W     = 31;
  localparam int STOCK_W     = 2;
  localparam int ENTRIES_W   = 4;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 8;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_REDUCE = 1'b1;

  typedef struct packed {
    logic add_en;
    logic red_en;
    logic force_del;
  } obar_cmd_t;

endpackage
`default_nettype wire

/* hdl/order_book_add_reduce_unit.sv */
`default_nettype none
// Order book with one table of BOOK_DEPTH slots per stock, held in a row of
// cells, slot k of every stock in cell k. Each beat is captured in ST_IDLE;
// then in ST_EXEC every cell compares its id at once, the lowest filled
// match is picked along the chain, and the add, subtract or shift-down is
// written. A result stalled at the output holds the next beat, once captured,
// ahead of its write cycle until the result is taken.
module order_book_add_reduce_unit #(
  parameter int BOOK_DEPTH = obar_pkg::BOOK_DEPTH_DEF,
  parameter int NUM_STOCKS = obar_pkg::NUM_STOCKS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // stock, id, price, quantity, force_delete, reference_best, pad
  input  wire  [obar_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action
  input  wire                               in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // is_new_best, stored, found, removed, entries_in_book
  output logic [obar_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import obar_pkg::*;

  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int SW = (NUM_STOCKS > 1) ? $clog2(NUM_STOCKS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic               act_r;
  logic [STOCK_W-1:0] stock_r;
  logic [FIELD_W-1:0] id_r;
  logic [FIELD_W-1:0] price_r;
  logic [FIELD_W-1:0] qty_r;
  logic               force_r;
  logic [FIELD_W-1:0] refb_r;

  logic [CW-1:0] cnt_r [NUM_STOCKS];

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic              in_acc;
  logic              go;
  logic [31:0]       stk32;
  logic              stk_ok;
  logic [SW-1:0]     stk_idx;
  logic [CW-1:0]     cnt_cur;
  logic [CW-1:0]     cnt_new;
  logic [31:0]       cnt_ext;
  logic [ENTRIES_W-1:0] entries;
  obar_cmd_t         cmd;
  logic              new_best;
  logic              found;
  logic              removed;

  logic [FIELD_W-1:0] cell_id    [BOOK_DEPTH];
  logic [FIELD_W-1:0] cell_price [BOOK_DEPTH];
  logic [FIELD_W-1:0] cell_qty   [BOOK_DEPTH];
  logic               hit_c      [BOOK_DEPTH+1];
  logic               shift_c    [BOOK_DEPTH+1];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign go        = (state_r == ST_EXEC) && (!out_tvalid_r || out_tready);

  assign stk32   = 32'(stock_r);
  assign stk_ok  = stk32 < 32'(NUM_STOCKS);
  assign stk_idx = stk32[SW-1:0];
  assign cnt_cur = cnt_r[stk_idx];

  always_comb begin
    cmd.add_en    = go && stk_ok && (act_r == ACT_ADD) && (32'(cnt_cur) < 32'(BOOK_DEPTH));
    cmd.red_en    = go && stk_ok && (act_r == ACT_REDUCE);
    cmd.force_del = force_r;
  end

  assign hit_c[0]   = 1'b0;
  assign shift_c[0] = 1'b0;
  assign found      = hit_c[BOOK_DEPTH];
  assign removed    = shift_c[BOOK_DEPTH];
  assign new_best   = stk_ok && (act_r == ACT_ADD) && (price_r > refb_r);

  genvar k;
  generate
    for (k = 0; k < BOOK_DEPTH; k++) begin : g_cell
      logic [FIELD_W-1:0] nb_id, nb_price, nb_qty;
      if (k == BOOK_DEPTH - 1) begin : g_last
        assign nb_id    = cell_id[k];
        assign nb_price = cell_price[k];
        assign nb_qty   = cell_qty[k];
      end else begin : g_mid
        assign nb_id    = cell_id[k+1];
        assign nb_price = cell_price[k+1];
        assign nb_qty   = cell_qty[k+1];
      end
      obar_cell #(
        .NUM_STOCKS (NUM_STOCKS),
        .BOOK_DEPTH (BOOK_DEPTH),
        .IDX        (k)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .stk       (stk_idx),
        .ord_id    (id_r),
        .price     (price_r),
        .qty       (qty_r),
        .count     (cnt_cur),
        .hit_in    (hit_c[k]),
        .shift_in  (shift_c[k]),
        .hit_out   (hit_c[k+1]),
        .shift_out (shift_c[k+1]),
        .nb_id     (nb_id),
        .nb_price  (nb_price),
        .nb_qty    (nb_qty),
        .id_o      (cell_id[k]),
        .price_o   (cell_price[k]),
        .qty_o     (cell_qty[k])
      );
    end
  endgenerate

  always_comb begin
    cnt_new = cnt_cur;
    if (cmd.add_en) begin
      cnt_new = cnt_cur + CW'(1);
    end else if (removed) begin
      cnt_new = cnt_cur - CW'(1);
    end
  end

  assign cnt_ext = 32'(cnt_new);
  assign entries = !stk_ok ? '0 :
                   (cnt_ext > 32'd15) ? ENTRIES_W'(15) : cnt_ext[ENTRIES_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (go) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < NUM_STOCKS; i++) cnt_r[i] <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (go && stk_ok) cnt_r[stk_idx] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= in_tuser;
      stock_r <= in_tdata[1:0];
      id_r    <= in_tdata[32:2];
      price_r <= in_tdata[63:33];
      qty_r   <= in_tdata[94:64];
      force_r <= in_tdata[95];
      refb_r  <= in_tdata[126:96];
    end
    if (go) begin
      out_tdata_r <= {entries, removed, found, cmd.add_en, new_best};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

/* hdl/obar_cell.sv */
`default_nettype none
module obar_cell #(
  parameter int NUM_STOCKS = 4,
  parameter int BOOK_DEPTH = 8,
  parameter int IDX        = 0
) (
  input  wire                                          clk,
  input  obar_pkg::obar_cmd_t                          cmd,
  input  wire  [((NUM_STOCKS > 1) ? $clog2(NUM_STOCKS) : 1)-1:0] stk,
  input  wire  [obar_pkg::FIELD_W-1:0]                 ord_id,
  input  wire  [obar_pkg::FIELD_W-1:0]                 price,
  input  wire  [obar_pkg::FIELD_W-1:0]                 qty,
  input  wire  [$clog2(BOOK_DEPTH+1)-1:0]              count,
  input  wire                                          hit_in,
  input  wire                                          shift_in,
  output logic                                         hit_out,
  output logic                                         shift_out,
  input  wire  [obar_pkg::FIELD_W-1:0]                 nb_id,
  input  wire  [obar_pkg::FIELD_W-1:0]                 nb_price,
  input  wire  [obar_pkg::FIELD_W-1:0]                 nb_qty,
  output logic [obar_pkg::FIELD_W-1:0]                 id_o,
  output logic [obar_pkg::FIELD_W-1:0]                 price_o,
  output logic [obar_pkg::FIELD_W-1:0]                 qty_o
);
  import obar_pkg::*;

  localparam int CW = $clog2(BOOK_DEPTH + 1);

  logic [FIELD_W-1:0] ids_r    [NUM_STOCKS];
  logic [FIELD_W-1:0] prices_r [NUM_STOCKS];
  logic [FIELD_W-1:0] qtys_r   [NUM_STOCKS];

  logic slot_valid;
  logic match;
  logic sel;
  logic rem;
  logic shift;
  logic wr_add;

  assign id_o    = ids_r[stk];
  assign price_o = prices_r[stk];
  assign qty_o   = qtys_r[stk];

  assign slot_valid = CW'(IDX) < count;
  assign match      = cmd.red_en && slot_valid && (id_o == ord_id);
  assign sel        = match && !hit_in;
  assign hit_out    = hit_in | match;
  assign rem        = cmd.force_del || (qty_o < qty);
  assign shift      = shift_in | (sel & rem);
  assign shift_out  = shift;
  assign wr_add     = cmd.add_en && (count == CW'(IDX));

  always_ff @(posedge clk) begin
    if (wr_add) begin
      ids_r[stk]    <= ord_id;
      prices_r[stk] <= price;
      qtys_r[stk]   <= qty;
    end else if (shift) begin
      ids_r[stk]    <= nb_id;
      prices_r[stk] <= nb_price;
      qtys_r[stk]   <= nb_qty;
    end else if (sel && !rem) begin
      qtys_r[stk]   <= qty_o - qty;
    end
  end

endmodule
`default_nettype wire

/* verif/order_book_add_reduce_unit_tb.sv */
module order_book_add_reduce_unit_tb;
  import obar_pkg::*;

  localparam int DEPTH       = BOOK_DEPTH_DEF;
  localparam int STOCKS      = NUM_STOCKS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [3:0] entries;
    logic       removed;
    logic       found;
    logic       stored;
    logic       new_best;
  } book_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [30:0] book_ids  [STOCKS][DEPTH];
  logic [30:0] book_px   [STOCKS][DEPTH];
  logic [30:0] book_qty  [STOCKS][DEPTH];
  int          book_fill [STOCKS];

  book_result_t pending_results[$];

  int err_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_adds = 0, n_full = 0, n_reduces = 0, n_found = 0, n_removed = 0;

  order_book_add_reduce_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic book_result_t apply_order(logic act, logic [1:0] stk, logic [30:0] id,
                                               logic [30:0] px, logic [30:0] qty, logic frc,
                                               logic [30:0] best_px);
    book_result_t r;
    int n;
    int slot;
    r = '0;
    if (act == ACT_ADD) begin
      n_adds++;
      r.new_best = px > best_px;
      if (book_fill[stk] < DEPTH) begin
        book_ids[stk][book_fill[stk]] = id;
        book_px[stk][book_fill[stk]]  = px;
        book_qty[stk][book_fill[stk]] = qty;
        book_fill[stk]++;
        r.stored = 1'b1;
      end else begin
        n_full++;
      end
    end else begin
      n_reduces++;
      n = book_fill[stk];
      slot = -1;
      for (int i = 0; i < n; i++) begin
        if (slot < 0 && book_ids[stk][i] == id) slot = i;
      end
      if (slot >= 0) begin
        r.found = 1'b1;
        n_found++;
        if (frc || book_qty[stk][slot] < qty) begin
          for (int k = slot; k + 1 < n; k++) begin
            book_ids[stk][k] = book_ids[stk][k+1];
            book_px[stk][k]  = book_px[stk][k+1];
            book_qty[stk][k] = book_qty[stk][k+1];
          end
          book_fill[stk]--;
          r.removed = 1'b1;
          n_removed++;
        end else begin
          book_qty[stk][slot] = book_qty[stk][slot] - qty;
        end
      end
    end
    r.entries = (book_fill[stk] > 15) ? 4'd15 : 4'(book_fill[stk]);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    err_count++;
  endtask

  task automatic check_result(book_result_t got);
    book_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result beat", int'(got), 0);
    end else begin
      want = pending_results.pop_front();
      if (got.new_best !== want.new_best)
        report_mismatch("is_new_best", int'(got.new_best), int'(want.new_best));
      if (got.stored !== want.stored)
        report_mismatch("stored", int'(got.stored), int'(want.stored));
      if (got.found !== want.found)
        report_mismatch("found", int'(got.found), int'(want.found));
      if (got.removed !== want.removed)
        report_mismatch("removed", int'(got.removed), int'(want.removed));
      if (got.entries !== want.entries)
        report_mismatch("entries_in_book", int'(got.entries), int'(want.entries));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(book_result_t'(out_tdata));
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_order(logic act, logic [1:0] stk, logic [30:0] id, logic [30:0] px,
                            logic [30:0] qty, logic frc, logic [30:0] best_px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom, $urandom, $urandom};
      in_tuser  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {1'b0, best_px, frc, qty, px, id, stk};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_order(act, stk, id, px, qty, frc, best_px));
  endtask

  task automatic wait_books_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_add_and_full();
    send_order(ACT_ADD, 2'd0, 31'd5, MAX31, 31'd100, 1'b0, MAX31 - 31'd1);
    send_order(ACT_ADD, 2'd0, 31'd5, 31'd0, MAX31, 1'b1, 31'd0);
    send_order(ACT_ADD, 2'd0, MAX31, 31'd12345, 31'd0, 1'b0, 31'd12345);
    for (int i = 0; i < 5; i++) begin
      send_order(ACT_ADD, 2'd0, 31'(i), 31'(1000 + i), 31'(50 + i), 1'b0, 31'd1000);
    end
    send_order(ACT_ADD, 2'd0, 31'd9, MAX31, 31'd1, 1'b0, 31'd0);
    send_order(ACT_ADD, 2'd1, 31'd0, 31'd1, 31'd1, 1'b0, 31'd0);
    send_order(ACT_ADD, 2'd2, 31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA, 1'b0,
               31'h5555_5554);
    send_order(ACT_ADD, 2'd3, MAX31, MAX31, MAX31, 1'b1, MAX31);
  endtask

  task automatic test_reduce_cases();
    send_order(ACT_REDUCE, 2'd0, 31'd5, 31'd0, 31'd100, 1'b0, 31'd0);
    send_order(ACT_REDUCE, 2'd0, 31'd5, 31'd0, 31'd1, 1'b0, 31'd0);
    send_order(ACT_REDUCE, 2'd0, 31'd5, 31'd0, MAX31, 1'b0, 31'd0);
    send_order(ACT_REDUCE, 2'd0, 31'd77, 31'd0, 31'd0, 1'b0, 31'd0);
    send_order(ACT_REDUCE, 2'd0, 31'd2, 31'd0, 31'd0, 1'b1, 31'd0);
    send_order(ACT_REDUCE, 2'd0, MAX31, 31'd0, 31'd0, 1'b0, 31'd0);
    send_order(ACT_REDUCE, 2'd1, 31'd0, 31'd0, 31'd0, 1'b1, 31'd0);
    send_order(ACT_REDUCE, 2'd1, 31'd0, 31'd0, 31'd0, 1'b0, 31'd0);
    send_order(ACT_REDUCE, 2'd3, MAX31, MAX31, MAX31, 1'b0, MAX31);
    send_order(ACT_REDUCE, 2'd2, 31'h2AAA_AAAA, 31'd0, 31'h2AAA_AAAB, 1'b0, 31'd0);
  endtask

  task automatic test_random_traffic(int count);
    logic        act;
    logic [1:0]  stk;
    logic [30:0] id, px, qty, best_px, q0;
    logic        frc;
    int          fill;
    for (int n = 0; n < count; n++) begin
      stk  = 2'($urandom_range(STOCKS - 1));
      fill = book_fill[stk];
      frc  = ($urandom_range(99) < 20);
      px   = 31'($urandom);
      case ($urandom_range(3))
        0: best_px = 31'($urandom);
        1: best_px = px;
        2: best_px = (px == 31'd0) ? 31'd0 : px - 31'd1;
        default: best_px = (px == MAX31) ? MAX31 : px + 31'd1;
      endcase
      if (fill == DEPTH) act = ($urandom_range(99) < 80) ? ACT_REDUCE : ACT_ADD;
      else if (fill == 0) act = ($urandom_range(99) < 80) ? ACT_ADD : ACT_REDUCE;
      else act = 1'($urandom_range(1));
      if ($urandom_range(99) < 10) begin
        // noise: anything goes
        id  = 31'($urandom);
        qty = 31'($urandom);
      end else if (act == ACT_ADD) begin
        id = ($urandom_range(99) < 75) ? 31'($urandom_range(15)) : 31'($urandom);
        case ($urandom_range(3))
          0: qty = 31'($urandom_range(1000));
          1: qty = 31'($urandom);
          2: qty = MAX31;
          default: qty = 31'd0;
        endcase
      end else begin
        if (fill > 0 && $urandom_range(99) < 75) begin
          fill = int'($urandom_range(fill - 1));
          id = book_ids[stk][fill];
          q0 = book_qty[stk][fill];
        end else begin
          id = 31'($urandom_range(15));
          q0 = 31'($urandom_range(1000));
        end
        case ($urandom_range(5))
          0: qty = q0;
          1: qty = (q0 == 31'd0) ? 31'd0 : 31'($urandom_range(32'(q0) - 32'd1));
          2: qty = (q0 == MAX31) ? MAX31 : q0 + 31'd1;
          3: qty = 31'd0;
          4: qty = 31'($urandom);
          default: qty = MAX31;
        endcase
      end
      send_order(act, stk, id, px, qty, frc, best_px);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 23;
    recv_idle_pct = 88;
    test_add_and_full();
    test_reduce_cases();
    test_random_traffic(526);
    wait_books_quiet();
    send_idle_pct = 88;
    recv_idle_pct = 23;
    test_random_traffic(526);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(526);
    wait_books_quiet();
    repeat (8) @(posedge clk);
    $display("Run covered %0d adds (%0d refused on a full book) and %0d reduces",
             n_adds, n_full, n_reduces);
    $display("Reduces matched %0d orders and deleted %0d of them", n_found, n_removed);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
